// ===== rtl/dls_pkg.sv =====
// Shared types, constants and saturating arithmetic helpers for the
// damped least-squares joint velocity core. No dependencies.
package dls_pkg;

    localparam int WIDE_W = 48;
    localparam int IN_W   = 32;
    localparam int IDX_W  = 3;
    localparam int CFG_W  = 31;

    typedef logic signed [WIDE_W-1:0] t_wide;

    localparam t_wide MAX48 = 48'sh7FFF_FFFF_FFFF;
    localparam t_wide MIN48 = 48'sh8000_0000_0000;

    localparam logic ACT_JACOBIAN = 1'b0;
    localparam logic ACT_TWIST    = 1'b1;

    typedef enum logic [0:0] {
        REG_DAMPING     = 1'b0,
        REG_SPEED_LIMIT = 1'b1
    } t_reg_idx;

    localparam logic [CFG_W-1:0] DAMPING_RESET     = 31'd6554;
    localparam logic [CFG_W-1:0] SPEED_LIMIT_RESET = 31'd65536;

    // Request to and response from the shared arithmetic units.
    typedef struct packed {
        logic  start;
        t_wide a;
        t_wide b;
    } t_op_req;

    typedef struct packed {
        logic  done;
        logic  flag;
        t_wide value;
    } t_op_rsp;

    typedef enum logic [5:0] {
        ST_IDLE,
        ST_LAM,
        ST_LAM_W,
        ST_GR_IA,
        ST_GR_IB,
        ST_GR_MS,
        ST_GR_MW,
        ST_GR_WR,
        ST_FA_INIT,
        ST_FA_RA0,
        ST_FA_R1,
        ST_FA_R2,
        ST_FA_M1,
        ST_FA_M2,
        ST_FA_END,
        ST_FA_DW,
        ST_FW_INIT,
        ST_FW_R0,
        ST_FW_R1,
        ST_FW_R2,
        ST_FW_MW,
        ST_FW_END,
        ST_DZ_RD,
        ST_DZ_GO,
        ST_DZ_W,
        ST_BK_INIT,
        ST_BK_R0,
        ST_BK_R1,
        ST_BK_R2,
        ST_BK_MW,
        ST_BK_END,
        ST_OU_IA,
        ST_OU_IB,
        ST_OU_MS,
        ST_OU_MW,
        ST_OU_EMIT
    } t_state;

    function automatic t_wide sat_add(input t_wide a, input t_wide b);
        logic signed [WIDE_W:0] s;
        s = {a[WIDE_W-1], a} + {b[WIDE_W-1], b};
        if (s[WIDE_W] != s[WIDE_W-1]) begin
            return s[WIDE_W] ? MIN48 : MAX48;
        end
        return s[WIDE_W-1:0];
    endfunction

    function automatic t_wide sat_sub(input t_wide a, input t_wide b);
        logic signed [WIDE_W:0] s;
        s = {a[WIDE_W-1], a} - {b[WIDE_W-1], b};
        if (s[WIDE_W] != s[WIDE_W-1]) begin
            return s[WIDE_W] ? MIN48 : MAX48;
        end
        return s[WIDE_W-1:0];
    endfunction

    function automatic t_wide sext_in(input logic [IN_W-1:0] v);
        return {{(WIDE_W-IN_W){v[IN_W-1]}}, v};
    endfunction

    // Magnitude as unsigned; the most negative value maps to 2^47.
    function automatic logic [WIDE_W-1:0] mag(input t_wide v);
        return v[WIDE_W-1] ? (~v + 48'd1) : v;
    endfunction

endpackage

// ===== rtl/dls_if.sv =====
// Handshake channel interfaces for the damped least-squares core:
// load items, joint velocity results and register writes. Uses dls_pkg.
interface dls_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [2:0]  row_index;
    logic [2:0]  column_index;
    logic signed [31:0] element_value;
    logic        final_item;

    modport source (output valid, action, row_index, column_index, element_value,
                    final_item, input ready);
    modport sink (input valid, action, row_index, column_index, element_value,
                  final_item, output ready);
endinterface

interface dls_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  joint_index;
    logic signed [31:0] joint_velocity;
    logic        singular;
    logic        last_joint;

    modport source (output valid, joint_index, joint_velocity, singular, last_joint,
                    input ready);
    modport sink (input valid, joint_index, joint_velocity, singular, last_joint,
                  output ready);
endinterface

interface dls_cfg_if;
    logic               valid;
    logic               ready;
    dls_pkg::t_reg_idx  index;
    logic [31:0]        data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/dls_mul.sv =====
// Saturating Q-format multiplier built from four 24x24 partial products.
// Start is followed by four partial-product steps, r_fin, then done. Depends on dls_pkg.
module dls_mul #(
    parameter int FRAC_BITS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  dls_pkg::t_op_req i_req,
    output dls_pkg::t_op_rsp o_rsp
);

    localparam int HW = 24;
    localparam int PW = 96;

    logic [47:0]    r_ma, n_ma, r_mb, n_mb;
    logic [PW-1:0]  r_prod, n_prod;
    logic           r_neg, n_neg;
    logic           r_busy, n_busy, r_fin, n_fin, r_done, n_done;
    logic [1:0]     r_step, n_step;
    dls_pkg::t_wide r_val, n_val;

    logic [HW-1:0]   sel_a, sel_b;
    logic [2*HW-1:0] pp;
    logic [PW-1:0]   pp_sh;
    logic            ovf;
    logic [46:0]     m;
    dls_pkg::t_wide  res;

    always_comb begin
        sel_a = r_step[0] ? r_ma[47:HW] : r_ma[HW-1:0];
        sel_b = r_step[1] ? r_mb[47:HW] : r_mb[HW-1:0];
        pp    = sel_a * sel_b;
        case (r_step) inside
            2'd0:       pp_sh = PW'(pp);
            2'd1, 2'd2: pp_sh = PW'(pp) << HW;
            default:    pp_sh = PW'(pp) << (2 * HW);
        endcase

        ovf = |r_prod[PW-1:47+FRAC_BITS];
        m   = r_prod[46+FRAC_BITS:FRAC_BITS];
        if (ovf) begin
            res = r_neg ? dls_pkg::MIN48 : dls_pkg::MAX48;
        end else if (r_neg) begin
            res = -$signed({1'b0, m});
        end else begin
            res = $signed({1'b0, m});
        end

        n_ma   = r_ma;
        n_mb   = r_mb;
        n_neg  = r_neg;
        n_prod = r_prod;
        n_step = r_step;
        n_busy = r_busy;
        n_fin  = 1'b0;
        n_done = 1'b0;
        n_val  = r_val;
        if (i_req.start) begin
            n_ma   = dls_pkg::mag(i_req.a);
            n_mb   = dls_pkg::mag(i_req.b);
            n_neg  = i_req.a[47] ^ i_req.b[47];
            n_prod = '0;
            n_step = 2'd0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_prod = r_prod + pp_sh;
            n_step = r_step + 2'd1;
            if (r_step == 2'd3) begin
                n_busy = 1'b0;
                n_fin  = 1'b1;
            end
        end
        if (r_fin) begin
            n_val  = res;
            n_done = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_step <= 2'd0;
        end else begin
            r_busy <= n_busy;
            r_fin  <= n_fin;
            r_done <= n_done;
            r_step <= n_step;
        end
        r_ma   <= n_ma;
        r_mb   <= n_mb;
        r_neg  <= n_neg;
        r_prod <= n_prod;
        r_val  <= n_val;
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.flag  = 1'b0;
    assign o_rsp.value = r_val;

endmodule

// ===== rtl/dls_div.sv =====
// Saturating Q-format divider, restoring, one quotient bit per cycle.
// A zero divisor answers without iterating, with a saturated value and the flag set. Depends on dls_pkg.
module dls_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  dls_pkg::t_op_req i_req,
    output dls_pkg::t_op_rsp o_rsp
);

    localparam int QW = 48 + FRAC_BITS;
    localparam int CW = $clog2(QW);

    logic [QW-1:0]  r_dvd, n_dvd, r_q, n_q;
    logic [47:0]    r_rem, n_rem, r_d, n_d;
    logic [CW-1:0]  r_cnt, n_cnt;
    logic           r_neg, n_neg;
    logic           r_busy, n_busy, r_fin, n_fin, r_done, n_done, r_dz, n_dz;
    dls_pkg::t_wide r_val, n_val;

    logic [48:0]    rs, diff;
    logic           ge;
    logic           ovf;
    logic [46:0]    m;
    dls_pkg::t_wide res;

    always_comb begin
        rs   = {r_rem, r_dvd[QW-1]};
        diff = rs - {1'b0, r_d};
        ge   = rs >= {1'b0, r_d};

        ovf = |r_q[QW-1:47];
        m   = r_q[46:0];
        if (ovf) begin
            res = r_neg ? dls_pkg::MIN48 : dls_pkg::MAX48;
        end else if (r_neg) begin
            res = -$signed({1'b0, m});
        end else begin
            res = $signed({1'b0, m});
        end

        n_dvd  = r_dvd;
        n_q    = r_q;
        n_rem  = r_rem;
        n_d    = r_d;
        n_cnt  = r_cnt;
        n_neg  = r_neg;
        n_busy = r_busy;
        n_fin  = 1'b0;
        n_done = 1'b0;
        n_dz   = r_dz;
        n_val  = r_val;
        if (i_req.start) begin
            if (i_req.b == '0) begin
                n_val  = i_req.a[47] ? dls_pkg::MIN48 : dls_pkg::MAX48;
                n_dz   = 1'b1;
                n_done = 1'b1;
            end else begin
                n_dvd  = {dls_pkg::mag(i_req.a), {FRAC_BITS{1'b0}}};
                n_d    = dls_pkg::mag(i_req.b);
                n_neg  = i_req.a[47] ^ i_req.b[47];
                n_rem  = '0;
                n_q    = '0;
                n_cnt  = CW'(QW - 1);
                n_dz   = 1'b0;
                n_busy = 1'b1;
            end
        end else if (r_busy) begin
            n_dvd = r_dvd << 1;
            n_rem = ge ? diff[47:0] : rs[47:0];
            n_q   = {r_q[QW-2:0], ge};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_fin  = 1'b1;
            end
        end
        if (r_fin) begin
            n_val  = res;
            n_done = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_fin  <= n_fin;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_dvd <= n_dvd;
        r_q   <= n_q;
        r_rem <= n_rem;
        r_d   <= n_d;
        r_neg <= n_neg;
        r_dz  <= n_dz;
        r_val <= n_val;
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.flag  = r_dz;
    assign o_rsp.value = r_val;

endmodule

// ===== rtl/damped_least_squares_joint_velocity_core.sv =====
// Damped least-squares joint velocity core: loads J and the twist, then forms
// J*J^T + lambda^2*I, factors it as L*D*L^T, solves and maps back through J^T.
// Load beats are taken while the core is idle; the final beat starts a solve that runs on
// the shared multiplier and divider, walking the memories one entry at a time. Joint beats
// then follow one another, later if the sink holds off; no load is taken meanwhile.
// Synchronous reset clears control state and both config registers; memories are not cleared.
module damped_least_squares_joint_velocity_core #(
    parameter int TASK_DIM    = 6,
    parameter int JOINT_COUNT = 7,
    parameter int FRAC_BITS   = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dls_in_if.sink    i_in,
    dls_out_if.source o_out,
    dls_cfg_if.sink   i_cfg
);

    localparam int JD   = TASK_DIM * JOINT_COUNT;
    localparam int GD   = TASK_DIM * TASK_DIM;
    localparam int JA_W = (JD > 1) ? $clog2(JD) : 1;
    localparam int GA_W = (GD > 1) ? $clog2(GD) : 1;
    localparam int TA_W = (TASK_DIM > 1) ? $clog2(TASK_DIM) : 1;
    localparam logic [2:0] T_LAST = 3'(TASK_DIM - 1);
    localparam logic [2:0] J_LAST = 3'(JOINT_COUNT - 1);

    function automatic logic [JA_W-1:0] f_jaddr(input logic [2:0] row, input logic [2:0] col);
        return JA_W'(int'(row) * JOINT_COUNT + int'(col));
    endfunction

    function automatic logic [GA_W-1:0] f_gaddr(input logic [2:0] row, input logic [2:0] col);
        return GA_W'(int'(row) * TASK_DIM + int'(col));
    endfunction

    // Memories.
    logic [31:0]    j_mem [JD];
    logic [31:0]    t_mem [TASK_DIM];
    dls_pkg::t_wide g_mem [GD];
    dls_pkg::t_wide s_mem [TASK_DIM];

    logic [31:0]    r_jrd, r_trd;
    dls_pkg::t_wide r_grd, r_srd;

    logic [JA_W-1:0] j_raddr, j_waddr;
    logic [TA_W-1:0] t_raddr, t_waddr;
    logic [GA_W-1:0] g_raddr, g_waddr;
    logic [TA_W-1:0] s_raddr, s_waddr;
    logic            j_we, t_we, g_we, s_we;
    dls_pkg::t_wide  g_wdata, s_wdata;

    // Registers.
    logic [dls_pkg::CFG_W-1:0] r_damp, r_limit;
    dls_pkg::t_state r_state, n_state;
    logic [2:0]      r_i, n_i, r_j, n_j, r_k, n_k, r_c, n_c;
    dls_pkg::t_wide  r_acc, n_acc, r_opa, n_opa, r_d, n_d, r_lam2, n_lam2;
    logic            r_sing, n_sing;
    logic            r_ov, n_ov;
    logic [2:0]      r_oj, n_oj;
    logic [31:0]     r_ovel, n_ovel;
    logic            r_osing, n_osing, r_olast, n_olast;

    dls_pkg::t_op_req mul_req, div_req;
    dls_pkg::t_op_rsp mul_rsp, div_rsp;

    logic           in_acc, row_ok, col_ok;
    dls_pkg::t_wide lim, nlim, vclamp;

    dls_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (mul_req),
        .o_rsp  (mul_rsp)
    );

    dls_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (div_req),
        .o_rsp  (div_rsp)
    );

    assign i_in.ready = (r_state == dls_pkg::ST_IDLE);
    assign in_acc     = i_in.valid && i_in.ready;
    assign row_ok     = {1'b0, i_in.row_index} < 4'(TASK_DIM);
    assign col_ok     = {1'b0, i_in.column_index} < 4'(JOINT_COUNT);

    assign j_we    = in_acc && (i_in.action == dls_pkg::ACT_JACOBIAN) && row_ok && col_ok;
    assign t_we    = in_acc && (i_in.action == dls_pkg::ACT_TWIST) && row_ok;
    assign j_waddr = f_jaddr(i_in.row_index, i_in.column_index);
    assign t_waddr = TA_W'(i_in.row_index);

    assign lim  = $signed({17'd0, r_limit});
    assign nlim = -lim;
    always_comb begin
        if (r_acc > lim) begin
            vclamp = lim;
        end else if (r_acc < nlim) begin
            vclamp = nlim;
        end else begin
            vclamp = r_acc;
        end
    end

    always_comb begin
        n_state = r_state;
        n_i     = r_i;
        n_j     = r_j;
        n_k     = r_k;
        n_c     = r_c;
        n_acc   = r_acc;
        n_opa   = r_opa;
        n_d     = r_d;
        n_lam2  = r_lam2;
        n_sing  = r_sing;
        n_ov    = (r_ov && o_out.ready) ? 1'b0 : r_ov;
        n_oj    = r_oj;
        n_ovel  = r_ovel;
        n_osing = r_osing;
        n_olast = r_olast;

        j_raddr = '0;
        t_raddr = '0;
        g_raddr = '0;
        s_raddr = '0;
        g_we    = 1'b0;
        g_waddr = '0;
        g_wdata = r_acc;
        s_we    = 1'b0;
        s_waddr = TA_W'(r_i);
        s_wdata = r_acc;

        mul_req.start = 1'b0;
        mul_req.a     = r_opa;
        mul_req.b     = r_acc;
        div_req.start = 1'b0;
        div_req.a     = r_acc;
        div_req.b     = r_d;

        unique case (r_state)
            dls_pkg::ST_IDLE: begin
                if (in_acc && i_in.final_item) begin
                    n_sing  = 1'b0;
                    n_i     = '0;
                    n_k     = '0;
                    n_c     = '0;
                    n_state = dls_pkg::ST_LAM;
                end
            end
            dls_pkg::ST_LAM: begin
                mul_req.start = 1'b1;
                mul_req.a     = $signed({17'd0, r_damp});
                mul_req.b     = $signed({17'd0, r_damp});
                n_state       = dls_pkg::ST_LAM_W;
            end
            dls_pkg::ST_LAM_W: begin
                if (mul_rsp.done) begin
                    n_lam2  = mul_rsp.value;
                    n_acc   = '0;
                    n_state = dls_pkg::ST_GR_IA;
                end
            end

            // Gram matrix, one product J(i,c)*J(k,c) per pass.
            dls_pkg::ST_GR_IA: begin
                j_raddr = f_jaddr(r_i, r_c);
                n_state = dls_pkg::ST_GR_IB;
            end
            dls_pkg::ST_GR_IB: begin
                n_opa   = dls_pkg::sext_in(r_jrd);
                j_raddr = f_jaddr(r_k, r_c);
                n_state = dls_pkg::ST_GR_MS;
            end
            dls_pkg::ST_GR_MS: begin
                mul_req.start = 1'b1;
                mul_req.b     = dls_pkg::sext_in(r_jrd);
                n_state       = dls_pkg::ST_GR_MW;
            end
            dls_pkg::ST_GR_MW: begin
                if (mul_rsp.done) begin
                    n_acc = dls_pkg::sat_add(r_acc, mul_rsp.value);
                    if (r_c < J_LAST) begin
                        n_c     = r_c + 3'd1;
                        n_state = dls_pkg::ST_GR_IA;
                    end else begin
                        n_state = dls_pkg::ST_GR_WR;
                    end
                end
            end
            dls_pkg::ST_GR_WR: begin
                g_we    = 1'b1;
                g_waddr = f_gaddr(r_i, r_k);
                g_wdata = (r_i == r_k) ? dls_pkg::sat_add(r_acc, r_lam2) : r_acc;
                n_acc   = '0;
                n_c     = '0;
                n_state = dls_pkg::ST_GR_IA;
                if (r_k < T_LAST) begin
                    n_k = r_k + 3'd1;
                end else begin
                    n_k = '0;
                    if (r_i < T_LAST) begin
                        n_i = r_i + 3'd1;
                    end else begin
                        n_i     = '0;
                        n_j     = '0;
                        n_state = dls_pkg::ST_FA_INIT;
                    end
                end
            end

            // LDL^T factorization in place: column j, rows i = j..last.
            dls_pkg::ST_FA_INIT: begin
                g_raddr = f_gaddr(r_i, r_j);
                n_state = dls_pkg::ST_FA_RA0;
            end
            dls_pkg::ST_FA_RA0: begin
                n_acc = r_grd;
                n_k   = '0;
                if (r_j == '0) begin
                    n_state = dls_pkg::ST_FA_END;
                end else begin
                    g_raddr = f_gaddr(r_j, 3'd0);
                    n_state = dls_pkg::ST_FA_R1;
                end
            end
            dls_pkg::ST_FA_R1: begin
                n_opa   = r_grd;
                g_raddr = f_gaddr(r_k, r_k);
                n_state = dls_pkg::ST_FA_R2;
            end
            dls_pkg::ST_FA_R2: begin
                mul_req.start = 1'b1;
                mul_req.b     = r_grd;
                g_raddr       = f_gaddr(r_i, r_k);
                n_state       = dls_pkg::ST_FA_M1;
            end
            dls_pkg::ST_FA_M1: begin
                // The read of L(i,k) is held so its data waits for the first product.
                g_raddr = f_gaddr(r_i, r_k);
                if (mul_rsp.done) begin
                    mul_req.start = 1'b1;
                    mul_req.a     = r_grd;
                    mul_req.b     = mul_rsp.value;
                    n_state       = dls_pkg::ST_FA_M2;
                end
            end
            dls_pkg::ST_FA_M2: begin
                if (mul_rsp.done) begin
                    n_acc = dls_pkg::sat_sub(r_acc, mul_rsp.value);
                    if (({1'b0, r_k} + 4'd1) < {1'b0, r_j}) begin
                        n_k     = r_k + 3'd1;
                        g_raddr = f_gaddr(r_j, r_k + 3'd1);
                        n_state = dls_pkg::ST_FA_R1;
                    end else begin
                        n_state = dls_pkg::ST_FA_END;
                    end
                end
            end
            dls_pkg::ST_FA_END: begin
                if (r_i == r_j) begin
                    g_we    = 1'b1;
                    g_waddr = f_gaddr(r_j, r_j);
                    g_wdata = r_acc;
                    n_d     = r_acc;
                    if (r_acc == '0) begin
                        n_sing = 1'b1;
                    end
                    if (r_i < T_LAST) begin
                        n_i     = r_i + 3'd1;
                        n_state = dls_pkg::ST_FA_INIT;
                    end else if (r_j < T_LAST) begin
                        n_j     = r_j + 3'd1;
                        n_i     = r_j + 3'd1;
                        n_state = dls_pkg::ST_FA_INIT;
                    end else begin
                        n_i     = '0;
                        n_state = dls_pkg::ST_FW_INIT;
                    end
                end else begin
                    div_req.start = 1'b1;
                    n_state       = dls_pkg::ST_FA_DW;
                end
            end
            dls_pkg::ST_FA_DW: begin
                if (div_rsp.done) begin
                    g_we    = 1'b1;
                    g_waddr = f_gaddr(r_i, r_j);
                    g_wdata = div_rsp.value;
                    n_sing  = r_sing | div_rsp.flag;
                    if (r_i < T_LAST) begin
                        n_i     = r_i + 3'd1;
                        n_state = dls_pkg::ST_FA_INIT;
                    end else if (r_j < T_LAST) begin
                        n_j     = r_j + 3'd1;
                        n_i     = r_j + 3'd1;
                        n_state = dls_pkg::ST_FA_INIT;
                    end else begin
                        n_i     = '0;
                        n_state = dls_pkg::ST_FW_INIT;
                    end
                end
            end

            // Forward substitution in L.
            dls_pkg::ST_FW_INIT: begin
                t_raddr = TA_W'(r_i);
                n_state = dls_pkg::ST_FW_R0;
            end
            dls_pkg::ST_FW_R0: begin
                n_acc = dls_pkg::sext_in(r_trd);
                n_k   = '0;
                if (r_i == '0) begin
                    n_state = dls_pkg::ST_FW_END;
                end else begin
                    g_raddr = f_gaddr(r_i, 3'd0);
                    n_state = dls_pkg::ST_FW_R1;
                end
            end
            dls_pkg::ST_FW_R1: begin
                n_opa   = r_grd;
                s_raddr = TA_W'(r_k);
                n_state = dls_pkg::ST_FW_R2;
            end
            dls_pkg::ST_FW_R2: begin
                mul_req.start = 1'b1;
                mul_req.b     = r_srd;
                n_state       = dls_pkg::ST_FW_MW;
            end
            dls_pkg::ST_FW_MW: begin
                if (mul_rsp.done) begin
                    n_acc = dls_pkg::sat_sub(r_acc, mul_rsp.value);
                    if (({1'b0, r_k} + 4'd1) < {1'b0, r_i}) begin
                        n_k     = r_k + 3'd1;
                        g_raddr = f_gaddr(r_i, r_k + 3'd1);
                        n_state = dls_pkg::ST_FW_R1;
                    end else begin
                        n_state = dls_pkg::ST_FW_END;
                    end
                end
            end
            dls_pkg::ST_FW_END: begin
                s_we = 1'b1;
                if (r_i < T_LAST) begin
                    n_i     = r_i + 3'd1;
                    n_state = dls_pkg::ST_FW_INIT;
                end else begin
                    n_i     = '0;
                    n_state = dls_pkg::ST_DZ_RD;
                end
            end

            // Scale by the inverse pivots.
            dls_pkg::ST_DZ_RD: begin
                s_raddr = TA_W'(r_i);
                g_raddr = f_gaddr(r_i, r_i);
                n_state = dls_pkg::ST_DZ_GO;
            end
            dls_pkg::ST_DZ_GO: begin
                div_req.start = 1'b1;
                div_req.a     = r_srd;
                div_req.b     = r_grd;
                n_state       = dls_pkg::ST_DZ_W;
            end
            dls_pkg::ST_DZ_W: begin
                if (div_rsp.done) begin
                    s_we    = 1'b1;
                    s_wdata = div_rsp.value;
                    n_sing  = r_sing | div_rsp.flag;
                    if (r_i < T_LAST) begin
                        n_i     = r_i + 3'd1;
                        n_state = dls_pkg::ST_DZ_RD;
                    end else begin
                        n_i     = T_LAST;
                        n_state = dls_pkg::ST_BK_INIT;
                    end
                end
            end

            // Backward substitution in L^T, last row first.
            dls_pkg::ST_BK_INIT: begin
                s_raddr = TA_W'(r_i);
                n_state = dls_pkg::ST_BK_R0;
            end
            dls_pkg::ST_BK_R0: begin
                n_acc = r_srd;
                n_k   = r_i + 3'd1;
                if (r_i == T_LAST) begin
                    n_state = dls_pkg::ST_BK_END;
                end else begin
                    g_raddr = f_gaddr(r_i + 3'd1, r_i);
                    n_state = dls_pkg::ST_BK_R1;
                end
            end
            dls_pkg::ST_BK_R1: begin
                n_opa   = r_grd;
                s_raddr = TA_W'(r_k);
                n_state = dls_pkg::ST_BK_R2;
            end
            dls_pkg::ST_BK_R2: begin
                mul_req.start = 1'b1;
                mul_req.b     = r_srd;
                n_state       = dls_pkg::ST_BK_MW;
            end
            dls_pkg::ST_BK_MW: begin
                if (mul_rsp.done) begin
                    n_acc = dls_pkg::sat_sub(r_acc, mul_rsp.value);
                    if (r_k < T_LAST) begin
                        n_k     = r_k + 3'd1;
                        g_raddr = f_gaddr(r_k + 3'd1, r_i);
                        n_state = dls_pkg::ST_BK_R1;
                    end else begin
                        n_state = dls_pkg::ST_BK_END;
                    end
                end
            end
            dls_pkg::ST_BK_END: begin
                s_we = 1'b1;
                if (r_i == '0) begin
                    n_c     = '0;
                    n_acc   = '0;
                    n_state = dls_pkg::ST_OU_IA;
                end else begin
                    n_i     = r_i - 3'd1;
                    n_state = dls_pkg::ST_BK_INIT;
                end
            end

            // Joint velocities: dq(c) = sum over i of J(i,c) * x(i), clamped to +/- the speed limit.
            dls_pkg::ST_OU_IA: begin
                j_raddr = f_jaddr(r_i, r_c);
                n_state = dls_pkg::ST_OU_IB;
            end
            dls_pkg::ST_OU_IB: begin
                n_opa   = dls_pkg::sext_in(r_jrd);
                s_raddr = TA_W'(r_i);
                n_state = dls_pkg::ST_OU_MS;
            end
            dls_pkg::ST_OU_MS: begin
                mul_req.start = 1'b1;
                mul_req.b     = r_srd;
                n_state       = dls_pkg::ST_OU_MW;
            end
            dls_pkg::ST_OU_MW: begin
                if (mul_rsp.done) begin
                    n_acc = dls_pkg::sat_add(r_acc, mul_rsp.value);
                    if (r_i < T_LAST) begin
                        n_i     = r_i + 3'd1;
                        n_state = dls_pkg::ST_OU_IA;
                    end else begin
                        n_state = dls_pkg::ST_OU_EMIT;
                    end
                end
            end
            dls_pkg::ST_OU_EMIT: begin
                if (!r_ov || o_out.ready) begin
                    n_ov    = 1'b1;
                    n_oj    = r_c;
                    n_ovel  = vclamp[31:0];
                    n_osing = r_sing;
                    n_olast = (r_c == J_LAST);
                    n_i     = '0;
                    n_acc   = '0;
                    if (r_c < J_LAST) begin
                        n_c     = r_c + 3'd1;
                        n_state = dls_pkg::ST_OU_IA;
                    end else begin
                        n_state = dls_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = dls_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (j_we) begin
            j_mem[j_waddr] <= i_in.element_value;
        end
        r_jrd <= j_mem[j_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (t_we) begin
            t_mem[t_waddr] <= i_in.element_value;
        end
        r_trd <= t_mem[t_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (g_we) begin
            g_mem[g_waddr] <= g_wdata;
        end
        r_grd <= g_mem[g_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (s_we) begin
            s_mem[s_waddr] <= s_wdata;
        end
        r_srd <= s_mem[s_raddr];
    end

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_damp  <= dls_pkg::DAMPING_RESET;
            r_limit <= dls_pkg::SPEED_LIMIT_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                dls_pkg::REG_DAMPING:     r_damp  <= i_cfg.data[30:0];
                dls_pkg::REG_SPEED_LIMIT: r_limit <= i_cfg.data[30:0];
                default: begin
                    r_damp <= r_damp;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dls_pkg::ST_IDLE;
            r_ov    <= 1'b0;
            r_sing  <= 1'b0;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
            r_c     <= '0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
            r_sing  <= n_sing;
            r_i     <= n_i;
            r_j     <= n_j;
            r_k     <= n_k;
            r_c     <= n_c;
        end
        r_acc   <= n_acc;
        r_opa   <= n_opa;
        r_d     <= n_d;
        r_lam2  <= n_lam2;
        r_oj    <= n_oj;
        r_ovel  <= n_ovel;
        r_osing <= n_osing;
        r_olast <= n_olast;
    end

    assign o_out.valid          = r_ov;
    assign o_out.joint_index    = r_oj;
    assign o_out.joint_velocity = r_ovel;
    assign o_out.singular       = r_osing;
    assign o_out.last_joint     = r_olast;

    a_units_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mul_req.start && div_req.start))
        else $error("multiplier and divider started together");

    a_mul_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_rsp.done |-> (r_state == dls_pkg::ST_LAM_W || r_state == dls_pkg::ST_GR_MW ||
                          r_state == dls_pkg::ST_FA_M1 || r_state == dls_pkg::ST_FA_M2 ||
                          r_state == dls_pkg::ST_FW_MW || r_state == dls_pkg::ST_BK_MW ||
                          r_state == dls_pkg::ST_OU_MW))
        else $error("product returned while the sequencer was not waiting");

    a_div_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == dls_pkg::ST_FA_DW || r_state == dls_pkg::ST_DZ_W))
        else $error("quotient returned while the sequencer was not waiting");

    a_last_then_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dls_pkg::ST_OU_EMIT && (!r_ov || o_out.ready) && r_c == J_LAST)
        |=> (r_state == dls_pkg::ST_IDLE && r_ov && r_olast))
        else $error("final joint beat did not end the solve");

endmodule

// ===== test/tb_damped_least_squares_joint_velocity_core.sv =====
// Self-checking testbench for the damped least-squares joint velocity core.
// Drives load beats and register writes, predicts every joint velocity result.
// Depends on dls_pkg, dls_if.sv and the core RTL.
`timescale 1ns / 1ps

class joint_velocity_scoreboard;
    localparam int ROWS   = 6;
    localparam int JOINTS = 7;
    localparam int FRAC   = 16;
    localparam longint W_MAX = 64'sh7FFF_FFFF_FFFF;
    localparam longint W_MIN = -W_MAX - 1;

    typedef struct {
        bit [2:0]  joint;
        bit [31:0] rate;
        bit        singular;
        bit        last;
    } t_joint_rate;

    longint      jac[ROWS][JOINTS];
    longint      twist[ROWS];
    longint      damping;
    longint      speed_limit;
    bit          pivot_zero;
    t_joint_rate expected_rates[$];
    int          errors;
    int          checked;
    int          singular_seen;

    function new();
        damping     = 6554;
        speed_limit = 65536;
        errors      = 0;
        checked     = 0;
        singular_seen = 0;
    endfunction

    function void write_reg(dls_pkg::t_reg_idx idx, bit [31:0] data);
        if (idx == dls_pkg::REG_DAMPING) begin
            damping = longint'(data[30:0]);
        end else begin
            speed_limit = longint'(data[30:0]);
        end
    endfunction

    function longint sat(longint v);
        if (v > W_MAX) return W_MAX;
        if (v < W_MIN) return W_MIN;
        return v;
    endfunction

    function longint from_mag(bit [127:0] m, bit neg);
        if (neg) begin
            if (m > 128'(W_MAX)) return W_MIN;
            return -longint'(m[63:0]);
        end
        if (m > 128'(W_MAX)) return W_MAX;
        return longint'(m[63:0]);
    endfunction

    function bit [63:0] abs_of(longint v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    function longint q_mul(longint a, longint b);
        bit [127:0] p;
        p = {64'd0, abs_of(a)} * {64'd0, abs_of(b)};
        p = p >> FRAC;
        return from_mag(p, (a < 0) != (b < 0));
    endfunction

    function longint q_div(longint num, longint den);
        bit [127:0] q;
        if (den == 0) begin
            pivot_zero = 1;
            return (num < 0) ? W_MIN : W_MAX;
        end
        q = ({64'd0, abs_of(num)} << FRAC) / {64'd0, abs_of(den)};
        return from_mag(q, (num < 0) != (den < 0));
    endfunction

    // Forms the damped Gram matrix, factors it, solves and maps back to joints.
    function void solve_joint_rates();
        longint g[ROWS][ROWS];
        longint x[ROWS];
        longint lam2;
        longint acc;
        longint v;
        t_joint_rate r;
        lam2 = q_mul(damping, damping);
        pivot_zero = 0;
        for (int i = 0; i < ROWS; i++) begin
            for (int k = 0; k < ROWS; k++) begin
                acc = 0;
                for (int c = 0; c < JOINTS; c++) acc = sat(acc + q_mul(jac[i][c], jac[k][c]));
                if (i == k) acc = sat(acc + lam2);
                g[i][k] = acc;
            end
        end
        for (int j = 0; j < ROWS; j++) begin
            acc = g[j][j];
            for (int k = 0; k < j; k++) acc = sat(acc - q_mul(g[j][k], q_mul(g[j][k], g[k][k])));
            g[j][j] = acc;
            if (acc == 0) pivot_zero = 1;
            for (int i = j + 1; i < ROWS; i++) begin
                v = g[i][j];
                for (int k = 0; k < j; k++) v = sat(v - q_mul(g[i][k], q_mul(g[j][k], g[k][k])));
                g[i][j] = q_div(v, acc);
            end
        end
        for (int i = 0; i < ROWS; i++) begin
            v = twist[i];
            for (int k = 0; k < i; k++) v = sat(v - q_mul(g[i][k], x[k]));
            x[i] = v;
        end
        for (int i = 0; i < ROWS; i++) x[i] = q_div(x[i], g[i][i]);
        for (int i = ROWS - 1; i >= 0; i--) begin
            v = x[i];
            for (int k = i + 1; k < ROWS; k++) v = sat(v - q_mul(g[k][i], x[k]));
            x[i] = v;
        end
        for (int c = 0; c < JOINTS; c++) begin
            v = 0;
            for (int i = 0; i < ROWS; i++) v = sat(v + q_mul(jac[i][c], x[i]));
            if (v > speed_limit) v = speed_limit;
            if (v < -speed_limit) v = -speed_limit;
            r.joint    = 3'(c);
            r.rate     = v[31:0];
            r.singular = pivot_zero;
            r.last     = (c == JOINTS - 1);
            expected_rates.push_back(r);
        end
        if (pivot_zero) singular_seen++;
    endfunction

    function void note_load(bit act, bit [2:0] row, bit [2:0] col, bit signed [31:0] val,
                            bit fin);
        if (act == dls_pkg::ACT_JACOBIAN) begin
            if (row < ROWS && col < JOINTS) jac[row][col] = longint'(val);
        end else begin
            if (row < ROWS) twist[row] = longint'(val);
        end
        if (fin) solve_joint_rates();
    endfunction

    function void check_joint_result(bit [2:0] joint, bit [31:0] rate, bit sing, bit last);
        t_joint_rate e;
        if (expected_rates.size() == 0) begin
            $display("%0t: unexpected result joint %0d rate %h", $time, joint, rate);
            errors++;
            return;
        end
        e = expected_rates.pop_front();
        checked++;
        if (e.joint != joint) begin
            $display("%0t: joint_index expected %0d actual %0d", $time, e.joint, joint);
            errors++;
        end
        if (e.rate != rate) begin
            $display("%0t: joint_velocity (joint %0d) expected %h actual %h",
                     $time, e.joint, e.rate, rate);
            errors++;
        end
        if (e.singular != sing) begin
            $display("%0t: singular expected %0d actual %0d", $time, e.singular, sing);
            errors++;
        end
        if (e.last != last) begin
            $display("%0t: last_joint expected %0d actual %0d", $time, e.last, last);
            errors++;
        end
    endfunction

    function int pending();
        return expected_rates.size();
    endfunction
endclass

module tb_damped_least_squares_joint_velocity_core;

    localparam int QUIET_LIMIT = 40000;
    localparam int LONG_HOLD   = 6000;

    logic i_clk;
    logic i_rst_n;

    dls_in_if  in_ch();
    dls_out_if out_ch();
    dls_cfg_if cfg_ch();

    damped_least_squares_joint_velocity_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    joint_velocity_scoreboard sb = new();

    bit quiet_tail;
    bit long_hold_req;
    int loads_sent;
    int solves_sent;
    int cfg_writes;

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Result side: checks accepted beats and stalls in random bursts.
    initial begin
        int stall;
        stall = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid && out_ch.ready) begin
                sb.check_joint_result(out_ch.joint_index, out_ch.joint_velocity,
                                      out_ch.singular, out_ch.last_joint);
            end
            if (long_hold_req) begin
                long_hold_req = 0;
                stall = LONG_HOLD;
            end
            if (stall > 0) begin
                stall--;
                out_ch.ready <= 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
                stall = $urandom_range(1, 17) - 1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready) || !i_rst_n) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("damped_least_squares_joint_velocity_core: mismatch");
        $finish;
    end

    task automatic send_load(bit act, bit [2:0] row, bit [2:0] col, bit [31:0] val, bit fin);
        if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.action        <= act;
        in_ch.row_index     <= row;
        in_ch.column_index  <= col;
        in_ch.element_value <= val;
        in_ch.final_item    <= fin;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_load(act, row, col, val, fin);
        loads_sent++;
        if (fin) solves_sent++;
    endtask

    // Sender pauses until every result of the stream has been checked.
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (sb.pending() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(dls_pkg::t_reg_idx idx, bit [31:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        sb.write_reg(idx, data);
        cfg_writes++;
    endtask

    function automatic bit [31:0] rand_value();
        bit [31:0] v;
        case ($urandom_range(0, 7))
            0: v = $urandom();
            1: v = {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
            default: begin
                v = $urandom_range(0, 32'h0002_0000);
                if ($urandom_range(0, 1)) v = -v;
            end
        endcase
        return v;
    endfunction

    task automatic load_everything(bit [31:0] fixed, bit use_fixed);
        for (int r = 0; r < 6; r++) begin
            for (int c = 0; c < 7; c++) begin
                send_load(dls_pkg::ACT_JACOBIAN, 3'(r), 3'(c),
                          use_fixed ? fixed : rand_value(), 1'b0);
            end
        end
        for (int r = 0; r < 6; r++) begin
            send_load(dls_pkg::ACT_TWIST, 3'(r), 3'($urandom_range(0, 7)),
                      use_fixed ? fixed : rand_value(), r == 5);
        end
    endtask

    // Random groups of loads, each closed by a final beat.
    task automatic random_groups(int count);
        int n;
        bit [2:0] row;
        bit [2:0] col;
        n = 0;
        while (n < count) begin
            int len;
            len = $urandom_range(1, 12);
            for (int k = 0; k < len; k++) begin
                row = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(6, 7))
                                                   : 3'($urandom_range(0, 5));
                col = ($urandom_range(0, 15) == 0) ? 3'd7 : 3'($urandom_range(0, 6));
                send_load(bit'($urandom_range(0, 1)), row, col, rand_value(), k == len - 1);
                n++;
            end
        end
    endtask

    initial begin
        in_ch.valid         <= 1'b0;
        in_ch.action        <= dls_pkg::ACT_JACOBIAN;
        in_ch.row_index     <= 3'd0;
        in_ch.column_index  <= 3'd0;
        in_ch.element_value <= 32'd0;
        in_ch.final_item    <= 1'b0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.index        <= dls_pkg::REG_DAMPING;
        cfg_ch.data         <= 32'd0;
        i_rst_n             <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Bit 31 of the write data lies outside the 31-bit registers.
        write_reg(dls_pkg::REG_DAMPING, 32'h8000_199A);
        write_reg(dls_pkg::REG_SPEED_LIMIT, 32'h8001_0000);
        load_everything(32'd0, 1'b0);

        // Field extremes and elements that fall outside the matrix.
        send_load(dls_pkg::ACT_JACOBIAN, 3'd0, 3'd0, 32'h7FFF_FFFF, 1'b1);
        send_load(dls_pkg::ACT_JACOBIAN, 3'd5, 3'd6, 32'h8000_0000, 1'b1);
        send_load(dls_pkg::ACT_TWIST, 3'd5, 3'd7, 32'h8000_0000, 1'b0);
        send_load(dls_pkg::ACT_TWIST, 3'd0, 3'd3, 32'h7FFF_FFFF, 1'b1);
        send_load(dls_pkg::ACT_JACOBIAN, 3'd7, 3'd7, 32'h1234_5678, 1'b1);
        send_load(dls_pkg::ACT_JACOBIAN, 3'd3, 3'd7, 32'hFFFF_FFFF, 1'b1);
        send_load(dls_pkg::ACT_TWIST, 3'd6, 3'd0, 32'h0001_0000, 1'b1);
        drain();

        // Zero damping and an all-zero first row give a zero pivot.
        write_reg(dls_pkg::REG_DAMPING, 32'd0);
        write_reg(dls_pkg::REG_SPEED_LIMIT, 32'h7FFF_FFFF);
        for (int c = 0; c < 7; c++) begin
            send_load(dls_pkg::ACT_JACOBIAN, 3'd0, 3'(c), 32'd0, c == 6);
        end
        drain();
        write_reg(dls_pkg::REG_SPEED_LIMIT, 32'd0);
        send_load(dls_pkg::ACT_TWIST, 3'd2, 3'd0, 32'hFFFE_0000, 1'b1);
        drain();
        write_reg(dls_pkg::REG_DAMPING, 32'h7FFF_FFFF);
        write_reg(dls_pkg::REG_SPEED_LIMIT, 32'h0002_0000);
        send_load(dls_pkg::ACT_JACOBIAN, 3'd1, 3'd1, 32'h0000_8000, 1'b1);
        drain();

        for (int p = 0; p < 4; p++) begin
            write_reg(dls_pkg::REG_DAMPING,
                      (p == 2) ? 32'd0 : $urandom_range(0, 32'h0002_0000));
            write_reg(dls_pkg::REG_SPEED_LIMIT,
                      (p == 1) ? 32'h7FFF_FFFF
                               : $urandom_range(32'h0000_1000, 32'h0004_0000));
            if (p == 1) begin
                // Results back up while loads keep coming.
                long_hold_req = 1;
            end
            if (p == 3) quiet_tail = 1;
            random_groups(74);
            drain();
        end
        repeat (50) @(posedge i_clk);

        $display("Sent %0d load beats closing %0d solves over %0d register writes.",
                 loads_sent, solves_sent, cfg_writes);
        $display("Checked %0d joint results, %0d solves with a zero pivot.",
                 sb.checked, sb.singular_seen);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("damped_least_squares_joint_velocity_core: match");
        end else begin
            $display("damped_least_squares_joint_velocity_core: mismatch");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/dls_pkg.sv
rtl/dls_if.sv
rtl/dls_mul.sv
rtl/dls_div.sv
rtl/damped_least_squares_joint_velocity_core.sv
test/tb_damped_least_squares_joint_velocity_core.sv
